// ----- rtl/proximity_trigger_zone_defines.svh -----
// ----------------------------------------------------------------------------
// Proximity trigger zone: assertion macros
// Concurrent checks, removed when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_TRIGGER_ZONE_DEFINES_SVH
`define PROXIMITY_TRIGGER_ZONE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define PTZ_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("proximity_trigger_zone: check failed");

`define PTZ_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("proximity_trigger_zone: check failed");

`else

`define PTZ_ASSERT_SAME(lbl, ck, rs, ante, cons)

`define PTZ_ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

// ----- rtl/ptz_pkg.sv -----
// ----------------------------------------------------------------------------
// Proximity trigger zone: package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package ptz_pkg;

  localparam int COORD_W    = 16;
  localparam int SPEED_W    = 16;
  localparam int DIST_W     = 34;
  localparam int SQ_W       = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 34;
  localparam int QUEUE_DEPTH = 8;

  localparam logic [DIST_W-1:0] RELEASE_R2_RST  = DIST_W'(25);
  localparam logic [DIST_W-1:0] TRIGGER_R2_RST  = DIST_W'(9);
  localparam logic [DIST_W-1:0] APPROACH_R2_RST = DIST_W'(36);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_CENTER_Z    = 3'd2,
    REG_RELEASE_R2  = 3'd3,
    REG_TRIGGER_R2  = 3'd4,
    REG_APPROACH_R2 = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [DIST_W-1:0]         release_r2;
    logic [DIST_W-1:0]         trigger_r2;
    logic [DIST_W-1:0]         approach_r2;
  } cfg_t;

  typedef struct packed {
    logic [DIST_W-1:0]         dist_sq;
    logic signed [SPEED_W-1:0] speed;
    logic                      point_valid;
    logic                      frame_last;
  } entry_t;

endpackage

// ----- rtl/ptz_if.sv -----
// ----------------------------------------------------------------------------
// Proximity trigger zone: channel interfaces
// Point channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ptz_point_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ptz_pkg::COORD_W-1:0]   point_x;
  logic signed [ptz_pkg::COORD_W-1:0]   point_y;
  logic signed [ptz_pkg::COORD_W-1:0]   point_z;
  logic signed [ptz_pkg::SPEED_W-1:0]   point_speed;
  logic                                 point_valid;
  logic                                 frame_last;

  modport source (output valid, point_x, point_y, point_z, point_speed, point_valid,
                  frame_last, input ready);
  modport sink (input valid, point_x, point_y, point_z, point_speed, point_valid,
                frame_last, output ready);
endinterface

interface ptz_result_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 is_triggered;
  logic                                 is_near;
  logic                                 trigger_changed;
  logic                                 near_changed;
  logic                                 trigger_record_on;
  logic signed [ptz_pkg::SPEED_W-1:0]   trigger_record_speed;
  logic                                 near_record_on;
  logic signed [ptz_pkg::SPEED_W-1:0]   near_record_speed;

  modport source (output valid, is_triggered, is_near, trigger_changed, near_changed,
                  trigger_record_on, trigger_record_speed, near_record_on,
                  near_record_speed, input ready);
  modport sink (input valid, is_triggered, is_near, trigger_changed, near_changed,
                trigger_record_on, trigger_record_speed, near_record_on,
                near_record_speed, output ready);
endinterface

// ----- rtl/proximity_trigger_zone.sv -----
// ----------------------------------------------------------------------------
// Proximity trigger zone
// Three-dimensional proximity button over a stream of tracked points.
// ----------------------------------------------------------------------------
// Points arrive as words on the points channel, one per tracked point, the
// last word of a frame flagged by frame_last (point_valid low marks a word
// that only closes the frame). One result word leaves on the results channel
// for each frame, carrying the press and approach flags, their change flags
// and the latched event records.
// Registers are written through cfg_we, cfg_index and cfg_data, by the user
// only while idle; the block itself does not enforce this.
// Throughput: one point word per cycle while points.ready is high, i.e. while
// queue and pipeline hold fewer than QUEUE_DEPTH words. A closing word passes
// the offset, square and sum registers and the queue to the result register.
// When the results receiver stalls, points keep flowing until the queue and
// the pipeline hold QUEUE_DEPTH words; only a closing word waits at the head.
// Reset clears the flags, records, queue and result register, and loads the
// register defaults (centre at the origin, radii squared of 25, 9 and 36).
// ----------------------------------------------------------------------------
`include "proximity_trigger_zone_defines.svh"

module proximity_trigger_zone #(
  parameter int QUEUE_DEPTH = ptz_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  ptz_point_if.sink                         points,
  ptz_result_if.source                      results,
  input  logic                              cfg_we,
  input  logic [ptz_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptz_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ptz_pkg::cfg_t   cfg;
  ptz_pkg::entry_t push_entry, head;
  logic            push, pop, empty;
  logic [1:0]      inflight;
  logic [CNT_W-1:0] q_count;
  logic [CNT_W:0]  occupancy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x    <= '0;
      cfg.center_y    <= '0;
      cfg.center_z    <= '0;
      cfg.release_r2  <= ptz_pkg::RELEASE_R2_RST;
      cfg.trigger_r2  <= ptz_pkg::TRIGGER_R2_RST;
      cfg.approach_r2 <= ptz_pkg::APPROACH_R2_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ptz_pkg::REG_CENTER_X:    cfg.center_x    <= cfg_data[ptz_pkg::COORD_W-1:0];
        ptz_pkg::REG_CENTER_Y:    cfg.center_y    <= cfg_data[ptz_pkg::COORD_W-1:0];
        ptz_pkg::REG_CENTER_Z:    cfg.center_z    <= cfg_data[ptz_pkg::COORD_W-1:0];
        ptz_pkg::REG_RELEASE_R2:  cfg.release_r2  <= cfg_data[ptz_pkg::DIST_W-1:0];
        ptz_pkg::REG_TRIGGER_R2:  cfg.trigger_r2  <= cfg_data[ptz_pkg::DIST_W-1:0];
        ptz_pkg::REG_APPROACH_R2: cfg.approach_r2 <= cfg_data[ptz_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  ptz_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .points     (points),
    .cfg        (cfg),
    .q_count    (q_count),
    .inflight   (inflight),
    .push       (push),
    .push_entry (push_entry)
  );

  ptz_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .count      (q_count)
  );

  ptz_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .head    (head),
    .empty   (empty),
    .pop     (pop),
    .results (results)
  );

  assign occupancy = (CNT_W+1)'(q_count) + (CNT_W+1)'(inflight);

  `PTZ_ASSERT_SAME(a_queue_room, clk, rst, 1'b1, occupancy <= (CNT_W+1)'(QUEUE_DEPTH))

  `PTZ_ASSERT_SAME(a_press_is_near, clk, rst, results.valid,
                   !results.is_triggered || results.is_near)

  `PTZ_ASSERT_SAME(a_trig_record, clk, rst, results.valid && results.trigger_changed,
                   results.trigger_record_on == results.is_triggered)

  `PTZ_ASSERT_NEXT(a_no_pop_empty, clk, rst, empty && !push, !pop)

endmodule

// ----- rtl/ptz_front.sv -----
// ----------------------------------------------------------------------------
// Proximity trigger zone: front end
// Accepts points and computes the squared distance to the centre in three
// stages: offsets, squares, sum.
// ----------------------------------------------------------------------------
module ptz_front #(
  parameter int DEPTH = ptz_pkg::QUEUE_DEPTH,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  ptz_point_if.sink            points,
  input  ptz_pkg::cfg_t        cfg,
  input  logic [CNT_W-1:0]     q_count,
  output logic [1:0]           inflight,
  output logic                 push,
  output ptz_pkg::entry_t      push_entry
);

  localparam int OFS_W = ptz_pkg::COORD_W + 1;

  logic                              s1_v, s2_v, s3_v;
  logic signed [OFS_W-1:0]           s1_dx, s1_dy, s1_dz;
  logic signed [ptz_pkg::SPEED_W-1:0] s1_speed, s2_speed, s3_speed;
  logic                              s1_pv, s2_pv, s3_pv;
  logic                              s1_last, s2_last, s3_last;
  logic [ptz_pkg::SQ_W-1:0]          s2_sqx, s2_sqy, s2_sqz;
  logic [ptz_pkg::DIST_W-1:0]        s3_d2;
  logic signed [2*OFS_W-1:0]         prod_x, prod_y, prod_z;
  logic [CNT_W:0]                    occ;
  logic                              accept;

  assign inflight = 2'(s1_v) + 2'(s2_v) + 2'(s3_v);
  assign occ      = (CNT_W+1)'(q_count) + (CNT_W+1)'(inflight);
  assign points.ready = occ < (CNT_W+1)'(DEPTH);
  assign accept   = points.valid && points.ready;

  assign prod_x = s1_dx * s1_dx;
  assign prod_y = s1_dy * s1_dy;
  assign prod_z = s1_dz * s1_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= accept;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_dx    <= {points.point_x[ptz_pkg::COORD_W-1], points.point_x}
              - {cfg.center_x[ptz_pkg::COORD_W-1], cfg.center_x};
    s1_dy    <= {points.point_y[ptz_pkg::COORD_W-1], points.point_y}
              - {cfg.center_y[ptz_pkg::COORD_W-1], cfg.center_y};
    s1_dz    <= {points.point_z[ptz_pkg::COORD_W-1], points.point_z}
              - {cfg.center_z[ptz_pkg::COORD_W-1], cfg.center_z};
    s1_speed <= points.point_speed;
    s1_pv    <= points.point_valid;
    s1_last  <= points.frame_last;

    s2_sqx   <= prod_x[ptz_pkg::SQ_W-1:0];
    s2_sqy   <= prod_y[ptz_pkg::SQ_W-1:0];
    s2_sqz   <= prod_z[ptz_pkg::SQ_W-1:0];
    s2_speed <= s1_speed;
    s2_pv    <= s1_pv;
    s2_last  <= s1_last;

    s3_d2    <= ptz_pkg::DIST_W'(s2_sqx) + ptz_pkg::DIST_W'(s2_sqy)
              + ptz_pkg::DIST_W'(s2_sqz);
    s3_speed <= s2_speed;
    s3_pv    <= s2_pv;
    s3_last  <= s2_last;
  end

  assign push                   = s3_v;
  assign push_entry.dist_sq     = s3_d2;
  assign push_entry.speed       = s3_speed;
  assign push_entry.point_valid = s3_pv;
  assign push_entry.frame_last  = s3_last;

endmodule

// ----- rtl/ptz_queue.sv -----
// ----------------------------------------------------------------------------
// Proximity trigger zone: word queue
// Short first-in first-out store between the front and back ends.
// ----------------------------------------------------------------------------
module ptz_queue #(
  parameter int DEPTH = ptz_pkg::QUEUE_DEPTH,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ptz_pkg::entry_t      push_entry,
  input  logic                 pop,
  output ptz_pkg::entry_t      head,
  output logic                 empty,
  output logic [CNT_W-1:0]     count
);

  ptz_pkg::entry_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;

  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/ptz_back.sv -----
// ----------------------------------------------------------------------------
// Proximity trigger zone: back end
// Tests distances against the radii, tracks the frame, closes it and holds
// the result word until taken.
// ----------------------------------------------------------------------------
module ptz_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ptz_pkg::cfg_t        cfg,
  input  ptz_pkg::entry_t      head,
  input  logic                 empty,
  output logic                 pop,
  ptz_result_if.source         results
);

  logic                               triggered, near;
  logic                               frame_hit, frame_near;
  logic signed [ptz_pkg::SPEED_W-1:0] frame_speed;
  logic                               trig_rec_on, near_rec_on;
  logic signed [ptz_pkg::SPEED_W-1:0] trig_rec_speed, near_rec_speed;
  logic                               out_valid, out_tchg, out_nchg;

  logic                               test, hit, approach;
  logic [ptz_pkg::DIST_W-1:0]         hit_r2;
  logic                               frame_hit_next, frame_near_next;
  logic signed [ptz_pkg::SPEED_W-1:0] frame_speed_next;
  logic                               tchg, nchg, close;

  assign pop    = !empty && (!head.frame_last || !out_valid || results.ready);
  assign close  = pop && head.frame_last;

  assign hit_r2   = triggered ? cfg.release_r2 : cfg.trigger_r2;
  assign test     = head.point_valid && !frame_hit;
  assign hit      = test && (head.dist_sq < hit_r2);
  assign approach = test && (head.dist_sq < cfg.approach_r2);

  assign frame_hit_next   = frame_hit || hit;
  assign frame_near_next  = frame_near || approach || hit;
  assign frame_speed_next = (hit || approach) ? head.speed : frame_speed;
  assign tchg             = frame_hit_next != triggered;
  assign nchg             = frame_near_next != near;

  always_ff @(posedge clk) begin
    if (rst) begin
      triggered      <= 1'b0;
      near           <= 1'b0;
      frame_hit      <= 1'b0;
      frame_near     <= 1'b0;
      frame_speed    <= '0;
      trig_rec_on    <= 1'b0;
      trig_rec_speed <= '0;
      near_rec_on    <= 1'b0;
      near_rec_speed <= '0;
      out_valid      <= 1'b0;
      out_tchg       <= 1'b0;
      out_nchg       <= 1'b0;
    end else begin
      if (close) begin
        triggered   <= frame_hit_next;
        near        <= frame_near_next;
        frame_hit   <= 1'b0;
        frame_near  <= 1'b0;
        frame_speed <= '0;
        if (tchg) begin
          trig_rec_on    <= frame_hit_next;
          trig_rec_speed <= frame_speed_next;
        end
        if (nchg) begin
          near_rec_on    <= frame_near_next;
          near_rec_speed <= frame_speed_next;
        end
        out_valid <= 1'b1;
        out_tchg  <= tchg;
        out_nchg  <= nchg;
      end else begin
        if (results.ready) begin
          out_valid <= 1'b0;
        end
        if (pop) begin
          frame_hit   <= frame_hit_next;
          frame_near  <= frame_near_next;
          frame_speed <= frame_speed_next;
        end
      end
    end
  end

  assign results.valid                = out_valid;
  assign results.is_triggered         = triggered;
  assign results.is_near              = near;
  assign results.trigger_changed      = out_tchg;
  assign results.near_changed         = out_nchg;
  assign results.trigger_record_on    = trig_rec_on;
  assign results.trigger_record_speed = trig_rec_speed;
  assign results.near_record_on       = near_rec_on;
  assign results.near_record_speed    = near_rec_speed;

endmodule
